// ===== rtl/core/ssdbm_pkg.sv =====
// shared constants, types and codes of the ssd block matcher
package ssdbm_pkg;

	localparam int MAX_WINDOW = 15;
	localparam int MAX_SHIFT = 128;
	localparam int MAX_WIDTH = 2048;
	localparam int PIXEL_BITS = 8;

	localparam int STORE_W = MAX_WIDTH + MAX_WINDOW;
	localparam int STORE_DEPTH = MAX_WINDOW * STORE_W;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int COL_W = 12;
	localparam int WS_W = 4;
	localparam int SHIFT_W = 8;
	localparam int CELLS = MAX_SHIFT + 1;
	localparam int COST_W =
		$clog2(MAX_WINDOW * MAX_WINDOW * ((2 ** PIXEL_BITS) - 1) * ((2 ** PIXEL_BITS) - 1) + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_DRAIN,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_WINDOW_SIZE   = 2'd1,
		REG_MAX_DISPARITY = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic accum;
		logic unload;
	} cell_ctl_t;

endpackage

// ===== rtl/core/ssdbm_ram.sv =====
// generic single write port, single read port ram with registered read
module ssdbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ssdbm_cell.sv =====
// one disparity cell: right pixel shift tap and running window cost
module ssdbm_cell (
	input  logic                                 clk,
	input  ssdbm_pkg::cell_ctl_t                 ctl,
	input  logic [ssdbm_pkg::PIXEL_BITS-1:0]     l_pix,
	input  logic [ssdbm_pkg::PIXEL_BITS-1:0]     r_in,
	output logic [ssdbm_pkg::PIXEL_BITS-1:0]     r_out,
	input  logic [ssdbm_pkg::COST_W-1:0]         cost_in,
	output logic [ssdbm_pkg::COST_W-1:0]         cost_out
);
	import ssdbm_pkg::*;

	logic [PIXEL_BITS-1:0]   r_q;
	logic [COST_W-1:0]       cost_q;
	logic [PIXEL_BITS-1:0]   diff;
	logic [2*PIXEL_BITS-1:0] sq;

	assign diff = (l_pix > r_q) ? (l_pix - r_q) : (r_q - l_pix);
	assign sq = diff * diff;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			r_q <= r_in;
		end
		if (ctl.clear) begin
			cost_q <= '0;
		end else if (ctl.accum) begin
			cost_q <= cost_q + COST_W'(sq);
		end else if (ctl.unload) begin
			cost_q <= cost_in;
		end
	end

	assign r_out = r_q;
	assign cost_out = cost_q;
endmodule

// ===== rtl/core/stereo_ssd_block_matcher_core.sv =====
// top level of the ssd stereo block matcher: line stores, cell chain and sequencer
//
//  channel  | dir | handshake        | content
//  s_*      | in  | s_tvalid/tready  | tdata: left, right pixel; tuser: frame start
//  m_*      | out | m_tvalid/tready  | tdata: disparity, row, column; tlast: row end
//  apb      | in  | psel/penable     | image_width, window_size, max_disparity
//
// an item with no result is taken while idle; after an item with a result, input
// stalls for the per-row sweep of the line store read port through the cell
// chain, over dl = min(column, max_disparity) shifts, and for the serial
// minimum search along the chain. reset clears counters and control only.
// a waiting result holds one output register; the next item is taken meanwhile.
module stereo_ssd_block_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // left_pixel, right_pixel
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // disparity, out_row, out_column, zero fill
	output logic        m_tlast,   // row_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ssdbm_pkg::*;

	logic [COL_W-1:0]   image_width_q;
	logic [WS_W-1:0]    window_size_q;
	logic [SHIFT_W-1:0] max_disparity_q;

	logic [COL_W-1:0]   w_eff;
	logic [WS_W-1:0]    ws_eff;
	logic [WS_W-1:0]    wsm1;
	logic [SHIFT_W-1:0] md_eff;
	logic [COL_W-1:0]   padded;

	logic [COL_W-1:0]  col_q, row_q, col_cur, row_cur, j_cur;
	logic [SLOT_W-1:0] slot_q, slot_cur, slot_inc, s0;
	logic [SLOT_W:0]   s0_sum;
	logic [COL_W:0]    col_nxt;
	logic              in_acc, emit;
	logic [SHIFT_W-1:0] dlim_cur;

	state_t state_q, state_d;

	logic [COL_W-1:0]   j_q, k0_q, xend_q, x_q;
	logic [SHIFT_W-1:0] dlim_q, scan_q, bestd_q;
	logic [WS_W-1:0]    wsm1_q, rcnt_q;
	logic [SLOT_W-1:0]  s_q, s_inc;
	logic               drain_q;
	logic [COST_W-1:0]  best_q;
	logic [10:0]        orow_q;
	logic               last_q;

	logic vld_s1, acc_s1, acc_s2;
	logic [PIXEL_BITS-1:0] l_s2;
	logic [PIXEL_BITS-1:0] l_rdata, r_rdata;
	logic [ADDR_W-1:0] waddr, raddr;
	logic              we;

	logic               out_v_q, out_load, out_last_q;
	logic [SHIFT_W-1:0] out_disp_q;
	logic [10:0]        out_row_q, out_col_q;

	cell_ctl_t ctl;
	logic [PIXEL_BITS-1:0] r_chain [CELLS+1];
	logic [COST_W-1:0]     cost_chain [CELLS+1];

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= COL_W'(1024);
			window_size_q <= WS_W'(7);
			max_disparity_q <= SHIFT_W'(64);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_index_t'(paddr[3:2]))
				REG_IMAGE_WIDTH: image_width_q <= pwdata[COL_W-1:0];
				REG_WINDOW_SIZE: window_size_q <= pwdata[WS_W-1:0];
				REG_MAX_DISPARITY: max_disparity_q <= pwdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
			REG_WINDOW_SIZE: prdata = 32'(window_size_q);
			REG_MAX_DISPARITY: prdata = 32'(max_disparity_q);
			default: prdata = '0;
		endcase
	end

	// clamped settings
	assign w_eff = (image_width_q == '0) ? COL_W'(1) :
		((image_width_q > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : image_width_q);
	assign ws_eff = (window_size_q == '0) ? WS_W'(1) :
		((window_size_q > WS_W'(MAX_WINDOW)) ? WS_W'(MAX_WINDOW) : window_size_q);
	assign md_eff = (max_disparity_q > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
		: max_disparity_q;
	assign wsm1 = ws_eff - WS_W'(1);
	assign padded = w_eff + COL_W'({ws_eff[WS_W-1:1], 1'b0});

	// input side position tracking
	assign in_acc = s_tvalid && s_tready;
	assign col_cur = s_tuser ? '0 : col_q;
	assign row_cur = s_tuser ? '0 : row_q;
	assign slot_cur = s_tuser ? '0 : slot_q;
	assign slot_inc = (slot_cur == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_cur + SLOT_W'(1);
	assign col_nxt = {1'b0, col_cur} + (COL_W+1)'(1);
	assign j_cur = col_cur - COL_W'(wsm1);
	assign emit = (row_cur >= COL_W'(wsm1)) && (col_cur >= COL_W'(wsm1)) && (j_cur < w_eff);
	assign dlim_cur = (j_cur > COL_W'(md_eff)) ? md_eff : j_cur[SHIFT_W-1:0];

	// slot of the top window row
	assign s0_sum = (SLOT_W+1)'(slot_cur) + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(wsm1);
	assign s0 = (s0_sum >= (SLOT_W+1)'(MAX_WINDOW)) ?
		SLOT_W'(s0_sum - (SLOT_W+1)'(MAX_WINDOW)) : SLOT_W'(s0_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			slot_q <= '0;
		end else if (in_acc) begin
			if (col_nxt >= (COL_W+1)'(padded)) begin
				col_q <= '0;
				row_q <= row_cur + COL_W'(1);
				slot_q <= slot_inc;
			end else begin
				col_q <= col_nxt[COL_W-1:0];
				row_q <= row_cur;
				slot_q <= slot_cur;
			end
		end
	end

	// line stores
	assign we = in_acc && (col_cur < COL_W'(STORE_W));
	assign waddr = ADDR_W'(int'(slot_cur) * STORE_W + int'(col_cur));
	assign raddr = ADDR_W'(int'(s_q) * STORE_W + int'(x_q));

	ssdbm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(STORE_DEPTH)) u_left_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(s_tdata[7:0]),
		.raddr(raddr), .rdata(l_rdata)
	);

	ssdbm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(STORE_DEPTH)) u_right_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(s_tdata[15:8]),
		.raddr(raddr), .rdata(r_rdata)
	);

	// sequencer
	assign s_inc = (s_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s_q + SLOT_W'(1);
	assign out_load = (state_q == ST_DONE) && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ready is high in idle only, so an accepted item is valid while idle
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && emit) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (x_q == xend_q && rcnt_q == wsm1_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.unload = 1'b1;
				if (scan_q == dlim_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		ctl.clear = (state_q == ST_IDLE) && s_tvalid && emit;
		ctl.shift = vld_s1;
		ctl.accum = acc_s2;
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			j_q <= j_cur;
			dlim_q <= dlim_cur;
			k0_q <= j_cur - COL_W'(dlim_cur);
			x_q <= j_cur - COL_W'(dlim_cur);
			xend_q <= col_cur;
			wsm1_q <= wsm1;
			s_q <= s0;
			rcnt_q <= '0;
			scan_q <= '0;
			drain_q <= 1'b0;
			orow_q <= 11'(row_cur - COL_W'(wsm1));
			last_q <= (j_cur == w_eff - COL_W'(1));
		end else begin
			case (state_q)
				ST_ROW: begin
					if (x_q == xend_q) begin
						if (rcnt_q != wsm1_q) begin
							rcnt_q <= rcnt_q + WS_W'(1);
							s_q <= s_inc;
							x_q <= k0_q;
						end
					end else begin
						x_q <= x_q + COL_W'(1);
					end
				end
				ST_DRAIN: drain_q <= 1'b1;
				ST_SCAN: begin
					// ascending shifts, ties go to the larger shift
					if (scan_q == '0 || cost_chain[0] <= best_q) begin
						best_q <= cost_chain[0];
						bestd_q <= scan_q;
					end
					if (scan_q != dlim_q) begin
						scan_q <= scan_q + SHIFT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// read pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_s1 <= 1'b0;
			acc_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_ROW);
			acc_s1 <= (state_q == ST_ROW) && (x_q >= j_q);
			acc_s2 <= vld_s1 && acc_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			l_s2 <= l_rdata;
		end
	end

	// cell chain, cell d sees right pixel x - d against left pixel x
	assign r_chain[0] = r_rdata;
	assign cost_chain[CELLS] = '0;

	for (genvar d = 0; d < CELLS; d++) begin : g_cell
		ssdbm_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.l_pix(l_s2),
			.r_in(r_chain[d]),
			.r_out(r_chain[d+1]),
			.cost_in(cost_chain[d+1]),
			.cost_out(cost_chain[d])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_disp_q <= bestd_q;
			out_row_q <= orow_q;
			out_col_q <= j_q[10:0];
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {2'b00, out_col_q, out_row_q, out_disp_q};
	assign m_tlast = out_last_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= dlim_q))
		else $error("scan ran past the last valid shift");

	a_accum_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s2 |-> (state_q == ST_ROW || state_q == ST_DRAIN))
		else $error("cost accumulated outside the window sweep");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW) |-> (x_q <= xend_q && rcnt_q <= wsm1_q))
		else $error("window sweep out of range");
endmodule
